/* rtl/bed_pkg.sv */
// shared types and constants for the bar endpoint detector
package bed_pkg;

    localparam int PIXEL_BITS    = 8;
    localparam int CONTRAST_BITS = 8;
    localparam int STATUS_BITS   = 2;
    // 3 * contrast needs two extra bits
    localparam int SCALED_BITS   = CONTRAST_BITS + 2;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_DROP   = 2'd0,
        STATUS_STOP   = 2'd1,
        STATUS_REJECT = 2'd2
    } bed_status_t;

    // decision for one row, passed from the evaluator to the top level
    typedef struct packed {
        logic        emit;      // row ends the run
        logic        computed;  // contrast was measured, history shifts
        logic        keep;      // no drop, recent center and row shift
        bed_status_t status;
    } bed_ctl_t;

endpackage

/* rtl/bed_if.sv */
// stream interfaces for row beats and endpoint beats
interface bed_row_if #(
    parameter int COORD_BITS = 12
);
    logic                            valid;
    logic                            ready;
    logic                            start_of_run;
    logic                            stop_row;
    logic                            dark_bar;
    logic [COORD_BITS-1:0]           row_index;
    logic [COORD_BITS-1:0]           left_x;
    logic [COORD_BITS-1:0]           center_x;
    logic [COORD_BITS-1:0]           right_x;
    logic [bed_pkg::PIXEL_BITS-1:0]  left_pixel;
    logic [bed_pkg::PIXEL_BITS-1:0]  center_pixel;
    logic [bed_pkg::PIXEL_BITS-1:0]  right_pixel;

    modport source (
        output valid, start_of_run, stop_row, dark_bar, row_index,
               left_x, center_x, right_x, left_pixel, center_pixel, right_pixel,
        input  ready
    );

    modport sink (
        input  valid, start_of_run, stop_row, dark_bar, row_index,
               left_x, center_x, right_x, left_pixel, center_pixel, right_pixel,
        output ready
    );
endinterface

interface bed_end_if #(
    parameter int COORD_BITS = 12
);
    logic                             valid;
    logic                             ready;
    logic [bed_pkg::STATUS_BITS-1:0]  status;
    logic [COORD_BITS-1:0]            end_x;
    logic [COORD_BITS-1:0]            end_y;

    modport source (
        output valid, status, end_x, end_y,
        input  ready
    );

    modport sink (
        input  valid, status, end_x, end_y,
        output ready
    );
endinterface

/* rtl/bed_row_eval.sv */
// per-row evaluation: crossing check, contrast and drop compare
module bed_row_eval #(
    parameter int COORD_BITS = 12
) (
    input  logic                               run_done,
    input  logic                               stop_row,
    input  logic                               dark_bar,
    input  logic [COORD_BITS-1:0]              row_index,
    input  logic [COORD_BITS-1:0]              left_x,
    input  logic [COORD_BITS-1:0]              center_x,
    input  logic [COORD_BITS-1:0]              right_x,
    input  logic [bed_pkg::PIXEL_BITS-1:0]     left_pixel,
    input  logic [bed_pkg::PIXEL_BITS-1:0]     center_pixel,
    input  logic [bed_pkg::PIXEL_BITS-1:0]     right_pixel,
    input  logic [bed_pkg::CONTRAST_BITS-1:0]  old_contrast,
    input  logic [COORD_BITS-1:0]              back2_x,
    input  logic [COORD_BITS-1:0]              back2_y,
    output bed_pkg::bed_ctl_t                  ctl,
    output logic [bed_pkg::CONTRAST_BITS-1:0]  contrast,
    output logic [COORD_BITS-1:0]              end_x,
    output logic [COORD_BITS-1:0]              end_y
);

    logic [bed_pkg::PIXEL_BITS-1:0]   diff_l;
    logic [bed_pkg::PIXEL_BITS-1:0]   diff_r;
    logic [bed_pkg::SCALED_BITS-1:0]  now_x3;
    logic [bed_pkg::SCALED_BITS-1:0]  old_x2;
    logic                             crossed;
    logic                             drop;

    assign diff_l = (center_pixel > left_pixel) ? center_pixel - left_pixel
                                                : left_pixel - center_pixel;
    assign diff_r = (center_pixel > right_pixel) ? center_pixel - right_pixel
                                                 : right_pixel - center_pixel;
    assign contrast = (diff_l > diff_r) ? diff_l : diff_r;

    assign now_x3 = {1'b0, contrast, 1'b0} + {2'b00, contrast};
    assign old_x2 = {1'b0, old_contrast, 1'b0};
    assign drop   = now_x3 < old_x2;

    // only a light bar can leave the span between its neighbours
    assign crossed = !dark_bar && ((center_x < left_x) || (center_x > right_x));

    always_comb
    begin
        ctl.emit     = 1'b0;
        ctl.computed = 1'b0;
        ctl.keep     = 1'b0;
        ctl.status   = bed_pkg::STATUS_STOP;
        end_x        = center_x;
        end_y        = row_index;
        if (!run_done)
        begin
            if (stop_row)
            begin
                ctl.emit   = 1'b1;
                ctl.status = bed_pkg::STATUS_STOP;
            end
            else if (crossed)
            begin
                ctl.emit   = 1'b1;
                ctl.status = bed_pkg::STATUS_REJECT;
                end_x      = '0;
                end_y      = '0;
            end
            else
            begin
                ctl.computed = 1'b1;
                if (drop)
                begin
                    ctl.emit   = 1'b1;
                    ctl.status = bed_pkg::STATUS_DROP;
                    end_x      = back2_x;
                    end_y      = back2_y;
                end
                else
                begin
                    ctl.keep = 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/bar_endpoint_detector.sv */
// top level of the bar endpoint detector
//
// rows: one beat per image row of a traced bar, carrying the run flags, the
//   columns of the bar and its two neighbour traces and the gray values there
// ends: one beat per finished run with status, endpoint column and row
//   (status drop, stop or reject; a rejected run reports zero coordinates)
// a run opens with start_of_run; rows outside a run are swallowed silently
// throughput: one row per cycle unless ends holds off; all work for a row is
//   one short pass from the input register through the evaluator into the
//   result register, which takes the result, if any, once it is free
// stall: while ends is held off, the result register holds and the input
//   register keeps its row; rows stays ready only while the input register
//   can drain, so no beat is lost or repeated
// reset: contrast history, recent centers and rows clear to zero at once and
//   the block idles (run done) until the next start_of_run; no clearing pass
// contrast history is a shift line of HISTORY_DEPTH-1 taps, the last tap is
//   the contrast seen HISTORY_DEPTH-1 rows back
module bar_endpoint_detector #(
    parameter int HISTORY_DEPTH = 8,
    parameter int COORD_BITS    = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    bed_row_if.sink     rows,
    bed_end_if.source   ends
);

    localparam int TAPS = HISTORY_DEPTH - 1;

    // input register
    logic                               s1_valid_reg;
    logic                               s1_start_reg;
    logic                               s1_stop_reg;
    logic                               s1_dark_reg;
    logic [COORD_BITS-1:0]              s1_row_reg;
    logic [COORD_BITS-1:0]              s1_lx_reg;
    logic [COORD_BITS-1:0]              s1_cx_reg;
    logic [COORD_BITS-1:0]              s1_rx_reg;
    logic [bed_pkg::PIXEL_BITS-1:0]     s1_lp_reg;
    logic [bed_pkg::PIXEL_BITS-1:0]     s1_cp_reg;
    logic [bed_pkg::PIXEL_BITS-1:0]     s1_rp_reg;

    // run state
    logic                               run_done_reg;
    logic                               run_done_next;
    logic [bed_pkg::CONTRAST_BITS-1:0]  hist_reg  [TAPS];
    logic [bed_pkg::CONTRAST_BITS-1:0]  hist_next [TAPS];
    logic [COORD_BITS-1:0]              col0_reg, col1_reg, row0_reg, row1_reg;
    logic [COORD_BITS-1:0]              col0_next, col1_next, row0_next, row1_next;

    // result register
    logic                               out_valid_reg;
    logic [bed_pkg::STATUS_BITS-1:0]    out_status_reg;
    logic [COORD_BITS-1:0]              out_x_reg;
    logic [COORD_BITS-1:0]              out_y_reg;

    logic                               advance;
    logic                               fire;
    logic                               eff_done;
    logic [bed_pkg::CONTRAST_BITS-1:0]  eff_old;
    logic [COORD_BITS-1:0]              eff_col0, eff_col1, eff_row0, eff_row1;
    bed_pkg::bed_ctl_t                  ctl;
    logic [bed_pkg::CONTRAST_BITS-1:0]  contrast;
    logic [COORD_BITS-1:0]              res_x;
    logic [COORD_BITS-1:0]              res_y;

    // the row in the input register moves on once the result slot is free
    assign advance    = !out_valid_reg || ends.ready;
    assign fire       = s1_valid_reg && advance;
    assign rows.ready = !s1_valid_reg || advance;

    // a start row sees a cleared run
    assign eff_done = s1_start_reg ? 1'b0 : run_done_reg;
    assign eff_old  = s1_start_reg ? '0 : hist_reg[TAPS-1];
    assign eff_col0 = s1_start_reg ? '0 : col0_reg;
    assign eff_col1 = s1_start_reg ? '0 : col1_reg;
    assign eff_row0 = s1_start_reg ? '0 : row0_reg;
    assign eff_row1 = s1_start_reg ? '0 : row1_reg;

    bed_row_eval #(
        .COORD_BITS (COORD_BITS)
    ) u_eval (
        .run_done     (eff_done),
        .stop_row     (s1_stop_reg),
        .dark_bar     (s1_dark_reg),
        .row_index    (s1_row_reg),
        .left_x       (s1_lx_reg),
        .center_x     (s1_cx_reg),
        .right_x      (s1_rx_reg),
        .left_pixel   (s1_lp_reg),
        .center_pixel (s1_cp_reg),
        .right_pixel  (s1_rp_reg),
        .old_contrast (eff_old),
        .back2_x      (eff_col1),
        .back2_y      (eff_row1),
        .ctl          (ctl),
        .contrast     (contrast),
        .end_x        (res_x),
        .end_y        (res_y)
    );

    // next run state
    always_comb
    begin
        run_done_next = run_done_reg;
        col0_next     = col0_reg;
        col1_next     = col1_reg;
        row0_next     = row0_reg;
        row1_next     = row1_reg;
        for (int i = 0; i < TAPS; i++)
        begin
            hist_next[i] = hist_reg[i];
        end
        if (fire)
        begin
            run_done_next = ctl.emit ? 1'b1 : eff_done;
            if (ctl.computed)
            begin
                // shift in the new contrast, dropping the oldest tap
                hist_next[0] = contrast;
                for (int i = 1; i < TAPS; i++)
                begin
                    hist_next[i] = s1_start_reg ? '0 : hist_reg[i-1];
                end
            end
            else if (s1_start_reg)
            begin
                for (int i = 0; i < TAPS; i++)
                begin
                    hist_next[i] = '0;
                end
            end
            if (ctl.keep)
            begin
                col1_next = eff_col0;
                row1_next = eff_row0;
                col0_next = s1_cx_reg;
                row0_next = s1_row_reg;
            end
            else if (s1_start_reg)
            begin
                col0_next = '0;
                col1_next = '0;
                row0_next = '0;
                row1_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            run_done_reg  <= 1'b1;
            col0_reg      <= '0;
            col1_reg      <= '0;
            row0_reg      <= '0;
            row1_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TAPS; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            if (rows.ready)
            begin
                s1_valid_reg <= rows.valid;
            end
            run_done_reg <= run_done_next;
            col0_reg     <= col0_next;
            col1_reg     <= col1_next;
            row0_reg     <= row0_next;
            row1_reg     <= row1_next;
            for (int i = 0; i < TAPS; i++)
            begin
                hist_reg[i] <= hist_next[i];
            end
            if (fire && ctl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (ends.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (rows.ready && rows.valid)
        begin
            s1_start_reg <= rows.start_of_run;
            s1_stop_reg  <= rows.stop_row;
            s1_dark_reg  <= rows.dark_bar;
            s1_row_reg   <= rows.row_index;
            s1_lx_reg    <= rows.left_x;
            s1_cx_reg    <= rows.center_x;
            s1_rx_reg    <= rows.right_x;
            s1_lp_reg    <= rows.left_pixel;
            s1_cp_reg    <= rows.center_pixel;
            s1_rp_reg    <= rows.right_pixel;
        end
        if (fire && ctl.emit)
        begin
            out_status_reg <= ctl.status;
            out_x_reg      <= res_x;
            out_y_reg      <= res_y;
        end
    end

    assign ends.valid  = out_valid_reg;
    assign ends.status = out_status_reg;
    assign ends.end_x  = out_x_reg;
    assign ends.end_y  = out_y_reg;

    // every result closes the run
    a_emit_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        fire && ctl.emit |=> run_done_reg)
        else $error("run still open after a result");

    // rows outside a run never make a result
    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !s1_start_reg && run_done_reg |-> !ctl.emit)
        else $error("result from a row outside a run");

    // a rejected run reports zero coordinates
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ends.valid && ends.status == bed_pkg::STATUS_REJECT
            |-> ends.end_x == '0 && ends.end_y == '0)
        else $error("rejected run with nonzero endpoint");

    // an empty input register always takes a beat
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> rows.ready)
        else $error("input stalled while empty");

endmodule

/* tb/sv/testbench.sv */
// self-checking testbench for the bar endpoint detector
`timescale 1ns / 100ps

module testbench;

    localparam int HISTORY_DEPTH = 8;
    localparam int COORD_BITS    = 12;
    localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
    // rows accepted by the detector, directed ones and swallowed ones included
    localparam int ROW_GOAL      = 650;
    // far above the slowest legal run, including the long sink hold-off
    localparam int RUN_LIMIT     = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int REPORT_LIMIT  = 10;

    // short status names for the directed table
    localparam bed_pkg::bed_status_t ST_DROP   = bed_pkg::STATUS_DROP;
    localparam bed_pkg::bed_status_t ST_STOP   = bed_pkg::STATUS_STOP;
    localparam bed_pkg::bed_status_t ST_REJECT = bed_pkg::STATUS_REJECT;

    // one row beat as the testbench sees it
    typedef struct packed {
        logic                           start_of_run;
        logic                           stop_row;
        logic                           dark_bar;
        logic [COORD_BITS-1:0]          row_index;
        logic [COORD_BITS-1:0]          left_x;
        logic [COORD_BITS-1:0]          center_x;
        logic [COORD_BITS-1:0]          right_x;
        logic [bed_pkg::PIXEL_BITS-1:0] left_pixel;
        logic [bed_pkg::PIXEL_BITS-1:0] center_pixel;
        logic [bed_pkg::PIXEL_BITS-1:0] right_pixel;
    } row_beat_t;

    // one endpoint beat
    typedef struct packed {
        bed_pkg::bed_status_t  status;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
    } end_beat_t;

    // directed stimulus row, with the endpoint typed in where it is obvious
    typedef struct packed {
        row_beat_t beat;
        logic      typed;
        end_beat_t want;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;

    bed_row_if #(.COORD_BITS(COORD_BITS)) rows_if ();
    bed_end_if #(.COORD_BITS(COORD_BITS)) ends_if ();

    bar_endpoint_detector #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .COORD_BITS    (COORD_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rows  (rows_if),
        .ends  (ends_if)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // shadow state of the detector
    logic [bed_pkg::CONTRAST_BITS-1:0] contrast_line [HISTORY_DEPTH];
    int                                line_pos;
    logic [COORD_BITS-1:0]             trail_cx  [2];   // centers one and two rows back
    logic [COORD_BITS-1:0]             trail_row [2];   // rows one and two rows back
    bit                                run_idle;

    end_beat_t     endpoint_queue [$];
    directed_row_t directed_rows  [$];

    int unsigned mismatch_count = 0;
    int unsigned sent_rows      = 0;
    int unsigned cycle_count    = 0;
    int          src_idle_pct   = 0;
    int          snk_idle_pct   = 0;
    bit          hold_go        = 1'b0;
    logic        ends_hold      = 1'b0;

    // clear contrast history and the recent centers and rows
    function automatic void clear_trace();
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            contrast_line[i] = '0;
        end
        line_pos     = 0;
        trail_cx[0]  = '0;
        trail_cx[1]  = '0;
        trail_row[0] = '0;
        trail_row[1] = '0;
    endfunction

    // step the shadow detector by one accepted row; 1 when the run ends here
    function automatic bit predict_endpoint(input row_beat_t b, output end_beat_t r);
        int gap_l;
        int gap_r;
        int now_c;
        int back_c;
        int slot;
        int cp;
        int lp;
        int rp;
        r.status = bed_pkg::STATUS_DROP;
        r.end_x  = '0;
        r.end_y  = '0;
        if (b.start_of_run)
        begin
            clear_trace();
            run_idle = 1'b0;
        end
        if (run_idle)
            return 1'b0;
        // stop row is reported as is, never checked
        if (b.stop_row)
        begin
            r.status = bed_pkg::STATUS_STOP;
            r.end_x  = b.center_x;
            r.end_y  = b.row_index;
            run_idle = 1'b1;
            return 1'b1;
        end
        // a light bar outside its neighbours kills the run
        if (!b.dark_bar && (b.center_x < b.left_x || b.center_x > b.right_x))
        begin
            r.status = bed_pkg::STATUS_REJECT;
            run_idle = 1'b1;
            return 1'b1;
        end
        cp    = int'(b.center_pixel);
        lp    = int'(b.left_pixel);
        rp    = int'(b.right_pixel);
        gap_l = cp > lp ? cp - lp : lp - cp;
        gap_r = cp > rp ? cp - rp : rp - cp;
        now_c = gap_l > gap_r ? gap_l : gap_r;
        slot  = line_pos;
        contrast_line[slot] = bed_pkg::CONTRAST_BITS'(now_c);
        back_c   = int'(contrast_line[(slot + 1) % HISTORY_DEPTH]);
        line_pos = (slot + 1) % HISTORY_DEPTH;
        // contrast fell below two thirds of the one HISTORY_DEPTH-1 rows back
        if (3 * now_c < 2 * back_c)
        begin
            r.status = bed_pkg::STATUS_DROP;
            r.end_x  = trail_cx[1];
            r.end_y  = trail_row[1];
            run_idle = 1'b1;
            return 1'b1;
        end
        trail_cx[1]  = trail_cx[0];
        trail_row[1] = trail_row[0];
        trail_cx[0]  = b.center_x;
        trail_row[0] = b.row_index;
        return 1'b0;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // compare an accepted endpoint beat with the oldest expectation
    task automatic check_endpoint();
        end_beat_t want;
        if (endpoint_queue.size() == 0)
        begin
            note_mismatch($sformatf("endpoint with none expected: status %0d x %0d y %0d",
                                    ends_if.status, ends_if.end_x, ends_if.end_y));
            return;
        end
        want = endpoint_queue.pop_front();
        if (ends_if.status !== want.status)
            note_mismatch($sformatf("status expected %0d actual %0d",
                                    want.status, ends_if.status));
        if (ends_if.end_x !== want.end_x)
            note_mismatch($sformatf("end_x expected %0d actual %0d",
                                    want.end_x, ends_if.end_x));
        if (ends_if.end_y !== want.end_y)
            note_mismatch($sformatf("end_y expected %0d actual %0d",
                                    want.end_y, ends_if.end_y));
    endtask

    // offer one row beat, wait for the handshake, then predict its endpoint
    task automatic send_row(input row_beat_t b, input bit typed, input end_beat_t want);
        end_beat_t pred;
        bit        produced;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            rows_if.valid <= 1'b0;
            @(posedge clk);
        end
        rows_if.valid        <= 1'b1;
        rows_if.start_of_run <= b.start_of_run;
        rows_if.stop_row     <= b.stop_row;
        rows_if.dark_bar     <= b.dark_bar;
        rows_if.row_index    <= b.row_index;
        rows_if.left_x       <= b.left_x;
        rows_if.center_x     <= b.center_x;
        rows_if.right_x      <= b.right_x;
        rows_if.left_pixel   <= b.left_pixel;
        rows_if.center_pixel <= b.center_pixel;
        rows_if.right_pixel  <= b.right_pixel;
        @(posedge clk);
        while (!rows_if.ready)
            @(posedge clk);
        sent_rows++;
        produced = predict_endpoint(b, pred);
        if (typed)
            endpoint_queue.push_back(want);
        else if (produced)
            endpoint_queue.push_back(pred);
    endtask

    // directed row; the endpoint fields matter only when typed is set
    function automatic void add_row(input bit sor, input bit stp, input bit drk,
                                    input int row, input int lx, input int cx, input int rx,
                                    input int lp, input int cp, input int rp,
                                    input bit typed, input bed_pkg::bed_status_t st,
                                    input int ex, input int ey);
        directed_row_t d;
        d.beat.start_of_run = sor;
        d.beat.stop_row     = stp;
        d.beat.dark_bar     = drk;
        d.beat.row_index    = COORD_BITS'(row);
        d.beat.left_x       = COORD_BITS'(lx);
        d.beat.center_x     = COORD_BITS'(cx);
        d.beat.right_x      = COORD_BITS'(rx);
        d.beat.left_pixel   = bed_pkg::PIXEL_BITS'(lp);
        d.beat.center_pixel = bed_pkg::PIXEL_BITS'(cp);
        d.beat.right_pixel  = bed_pkg::PIXEL_BITS'(rp);
        d.typed             = typed;
        d.want.status       = st;
        d.want.end_x        = COORD_BITS'(ex);
        d.want.end_y        = COORD_BITS'(ey);
        directed_rows.push_back(d);
    endfunction

    // pixels whose contrast max(|c-l|, |c-r|) is exactly t
    function automatic row_beat_t with_contrast(input int t);
        row_beat_t b;
        int        cp;
        int        far_px;
        int        near_px;
        b  = '0;
        cp = $urandom_range(0, 255);
        if (cp >= t)
            far_px = cp - t;
        else if (cp + t <= 255)
            far_px = cp + t;
        else
        begin
            cp     = t;
            far_px = 0;
        end
        near_px = $urandom_range(cp >= t ? cp - t : 0, cp + t > 255 ? 255 : cp + t);
        b.center_pixel = bed_pkg::PIXEL_BITS'(cp);
        if ($urandom_range(0, 1) == 1)
        begin
            b.left_pixel  = bed_pkg::PIXEL_BITS'(far_px);
            b.right_pixel = bed_pkg::PIXEL_BITS'(near_px);
        end
        else
        begin
            b.left_pixel  = bed_pkg::PIXEL_BITS'(near_px);
            b.right_pixel = bed_pkg::PIXEL_BITS'(far_px);
        end
        return b;
    endfunction

    // one traced bar: mostly a contrast plateau then a fall, mostly closed by a stop row
    task automatic send_random_run();
        row_beat_t             b;
        end_beat_t             no_want;
        int                    body_len;
        int                    plateau;
        int                    t_hi;
        int                    t;
        int                    cx;
        int                    lx;
        int                    rx;
        bit                    shaped;
        bit                    dark;
        bit                    stop_ends;
        logic [COORD_BITS-1:0] row_base;
        no_want.status = bed_pkg::STATUS_DROP;
        no_want.end_x  = '0;
        no_want.end_y  = '0;
        body_len  = $urandom_range(1, 16);
        plateau   = $urandom_range(6, 10);
        t_hi      = $urandom_range(30, 255);
        shaped    = $urandom_range(0, 4) != 0;
        dark      = 1'($urandom_range(0, 1));
        stop_ends = $urandom_range(0, 3) != 0;
        row_base  = COORD_BITS'($urandom);
        for (int k = 0; k <= body_len; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                dark = !dark;
            cx = $urandom_range(0, COORD_MAX);
            lx = $urandom_range(0, cx);
            rx = $urandom_range(cx, COORD_MAX);
            // now and then the center leaves the span of its neighbours
            if ($urandom_range(0, 19) == 0)
            begin
                if (cx == 0 || (cx != COORD_MAX && $urandom_range(0, 1) == 1))
                    lx = $urandom_range(cx + 1, COORD_MAX);
                else
                    rx = $urandom_range(0, cx - 1);
            end
            if (!shaped)
                t = $urandom_range(0, 255);
            else if (k < plateau)
                t = t_hi - $urandom_range(0, t_hi / 8);
            else
                t = $urandom_range(0, t_hi);
            b              = with_contrast(t);
            b.start_of_run = (k == 0);
            b.stop_row     = stop_ends && (k == body_len);
            b.dark_bar     = dark;
            b.row_index    = ($urandom_range(0, 19) == 0) ? COORD_BITS'($urandom)
                                                          : row_base + COORD_BITS'(k);
            b.left_x       = COORD_BITS'(lx);
            b.center_x     = COORD_BITS'(cx);
            b.right_x      = COORD_BITS'(rx);
            send_row(b, 1'b0, no_want);
        end
    endtask

    // a few beats of random content, start flag rare
    task automatic send_noise();
        row_beat_t b;
        end_beat_t no_want;
        int        burst;
        no_want.status = bed_pkg::STATUS_DROP;
        no_want.end_x  = '0;
        no_want.end_y  = '0;
        burst = $urandom_range(1, 3);
        repeat (burst)
        begin
            b.start_of_run = $urandom_range(0, 3) == 0;
            b.stop_row     = 1'($urandom_range(0, 1));
            b.dark_bar     = 1'($urandom_range(0, 1));
            b.row_index    = COORD_BITS'($urandom);
            b.left_x       = COORD_BITS'($urandom);
            b.center_x     = COORD_BITS'($urandom);
            b.right_x      = COORD_BITS'($urandom);
            b.left_pixel   = bed_pkg::PIXEL_BITS'($urandom);
            b.center_pixel = bed_pkg::PIXEL_BITS'($urandom);
            b.right_pixel  = bed_pkg::PIXEL_BITS'($urandom);
            send_row(b, 1'b0, no_want);
        end
    endtask

    // endpoint sink: check at each handshake, then pick next ready
    initial
    begin
        ends_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (ends_if.valid && ends_if.ready)
                check_endpoint();
            ends_if.ready <= !ends_hold && ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // long sink hold-off so the detector backs up and stalls its rows input
    initial
    begin
        int hold_cycles;
        wait (hold_go);
        @(posedge clk);
        ends_hold <= 1'b1;
        for (hold_cycles = 0; hold_cycles < HOLD_CYCLES; hold_cycles++)
            @(posedge clk);
        ends_hold <= 1'b0;
    end

    // run limit
    initial
    begin
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // stimulus
    initial
    begin
        rst_n                <= 1'b0;
        rows_if.valid        <= 1'b0;
        rows_if.start_of_run <= 1'b0;
        rows_if.stop_row     <= 1'b0;
        rows_if.dark_bar     <= 1'b0;
        rows_if.row_index    <= '0;
        rows_if.left_x       <= '0;
        rows_if.center_x     <= '0;
        rows_if.right_x      <= '0;
        rows_if.left_pixel   <= '0;
        rows_if.center_pixel <= '0;
        rows_if.right_pixel  <= '0;
        clear_trace();
        run_idle = 1'b1;

        //       sor stp drk row   lx    cx    rx    lp   cp   rp  typed status  x     y
        // idle after reset, swallowed
        add_row(0, 0, 1, 7,    0,    0,    0,    0,   0,   0,   0, ST_DROP,   0,    0);
        // start on a stop row, crossing ignored there
        add_row(1, 1, 0, 4095, 4095, 4095, 0,    255, 255, 255, 1, ST_STOP,   4095, 4095);
        // run done, swallowed
        add_row(0, 1, 0, 100,  0,    50,   100,  0,   0,   0,   0, ST_DROP,   0,    0);
        // light bar, full span, then center right of the right trace
        add_row(1, 0, 0, 0,    0,    0,    4095, 0,   255, 0,   0, ST_DROP,   0,    0);
        add_row(0, 0, 0, 1,    0,    4095, 4094, 0,   0,   0,   1, ST_REJECT, 0,    0);
        // dark bar may cross; seven rows at full contrast
        add_row(1, 0, 1, 10,   3000, 2000, 1000, 0,   255, 255, 0, ST_DROP,   0,    0);
        add_row(0, 0, 1, 11,   0,    2001, 4095, 255, 0,   0,   0, ST_DROP,   0,    0);
        add_row(0, 0, 1, 12,   0,    2002, 4095, 128, 0,   255, 0, ST_DROP,   0,    0);
        add_row(0, 0, 1, 13,   0,    2003, 4095, 255, 0,   128, 0, ST_DROP,   0,    0);
        add_row(0, 0, 1, 14,   0,    2004, 4095, 0,   255, 0,   0, ST_DROP,   0,    0);
        add_row(0, 0, 1, 15,   0,    2005, 4095, 255, 0,   255, 0, ST_DROP,   0,    0);
        add_row(0, 0, 1, 16,   0,    2006, 4095, 10,  255, 0,   0, ST_DROP,   0,    0);
        // exactly two thirds is no drop, one below is
        add_row(0, 0, 1, 17,   0,    2007, 4095, 85,  255, 255, 0, ST_DROP,   0,    0);
        add_row(0, 0, 1, 18,   0,    2008, 4095, 0,   169, 100, 0, ST_DROP,   0,    0);
        // center on both neighbours is fine, one left of the left trace is not
        add_row(1, 0, 0, 4095, 2048, 2048, 2048, 77,  77,  77,  0, ST_DROP,   0,    0);
        add_row(0, 0, 0, 0,    101,  100,  200,  0,   0,   0,   1, ST_REJECT, 0,    0);
        // stop row after one checked row
        add_row(1, 0, 0, 200,  0,    5,    10,   255, 0,   255, 0, ST_DROP,   0,    0);
        add_row(0, 1, 1, 201,  4095, 1234, 0,    3,   200, 9,   1, ST_STOP,   1234, 201);
        // crossing on the start row itself
        add_row(1, 0, 0, 250,  10,   9,    20,   0,   0,   0,   1, ST_REJECT, 0,    0);
        // start in the middle of a run restarts it
        add_row(1, 0, 1, 300,  0,    0,    0,    0,   0,   0,   0, ST_DROP,   0,    0);
        add_row(1, 0, 0, 301,  0,    4095, 4095, 255, 128, 0,   0, ST_DROP,   0,    0);
        add_row(0, 1, 0, 302,  4095, 4000, 0,    1,   2,   3,   1, ST_STOP,   4000, 302);

        src_idle_pct = 17;
        snk_idle_pct = 51;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_row(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

        // three idling phases, the last with the long sink hold-off
        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 51 : 0;
            snk_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 17 : 0;
            if (phase == 2)
                hold_go = 1'b1;
            while (sent_rows < ROW_GOAL * (phase + 1) / 3)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                else
                    send_random_run();
            end
        end

        // drain, then wait for anything unexpected to show up
        rows_if.valid <= 1'b0;
        while (endpoint_queue.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && endpoint_queue.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
